// File: hdl/qse_pkg.sv
// shared types and constants for the quicksort engine
`default_nettype none
package qse_pkg;

   localparam int unsigned StoreDepthDefault = 64;
   localparam int unsigned ValueWidth = 32;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value_in;
      logic                         is_last;
   } req_word_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value_out;
      logic                         last_out;
      logic                         overflow;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_POP,
      ST_POP_WAIT,
      ST_PIV_WAIT,
      ST_CMP,
      ST_SWP1,
      ST_SWP2,
      ST_FIN1,
      ST_FIN2,
      ST_PUSH,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage
`default_nettype wire

// File: hdl/qse_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module qse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic                       re,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr,
   output logic      [WIDTH-1:0]           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// File: hdl/quicksort_engine.sv
// quicksort engine: collects signed words, sorts them in place, streams them out in order
// load: one word per cycle, stall is high from the final word until the last result is queued
// sort: per partition, pop the range and fetch the pivot (ST_POP, ST_POP_WAIT, ST_PIV_WAIT),
//    compare each word (ST_CMP), swap a word below the pivot (ST_SWP1, ST_SWP2), then place
//    the pivot and push subranges (ST_FIN1 to ST_PUSH); all paced by the single value-ram read port
// emit: per result word one ram read, then one output load; the read waits while the consumer stalls
// reset: synchronous, clears fill count, drop flag, stack pointer, emit index, state and output valid
`default_nettype none
module quicksort_engine #(
   parameter int unsigned STORE_DEPTH = qse_pkg::StoreDepthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire qse_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output qse_pkg::rsp_word_type     rsp_word
);
   import qse_pkg::*;

   // index into the value store, count that can hold the depth itself
   localparam int unsigned IW = $clog2(STORE_DEPTH);
   localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
   localparam int unsigned SW = 2 * IW;

   state_type state_ff, state_in;

   // range registers of the partition in flight
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] place_ff, place_in;
   logic signed [ValueWidth-1:0] pivot_ff, pivot_in;
   logic signed [ValueWidth-1:0] hold_ff, hold_in;

   // stack pointer never passes half the depth: stacked ranges are disjoint, two wide at least
   logic [IW-1:0] sp_ff, sp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] idx_ff, idx_in;

   // output register
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   // value store ports
   logic                  vs_we, vs_re;
   logic [IW-1:0]         vs_waddr, vs_raddr;
   logic [ValueWidth-1:0] vs_wdata, vs_rdata;

   // range stack ports
   logic          rs_we, rs_re;
   logic [IW-1:0] rs_waddr, rs_raddr;
   logic [SW-1:0] rs_wdata, rs_rdata;

   // helpers
   logic          req_take;
   logic          store_full;
   logic [CW-1:0] load_cnt;
   logic [IW:0]   scan_next;
   logic          scan_more;
   logic          is_less;
   logic          out_free;
   logic          emit_last;
   logic [IW:0]   place_next;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_take   = req_valid && !req_stall;
   assign store_full = (fill_ff == CW'(STORE_DEPTH));
   assign load_cnt   = store_full ? fill_ff : fill_ff + CW'(1);
   assign scan_next  = {1'b0, scan_ff} + (IW+1)'(1);
   assign scan_more  = scan_next < {1'b0, hi_ff};
   assign place_next = {1'b0, place_ff} + (IW+1)'(1);
   assign is_less    = $signed(vs_rdata) < pivot_ff;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign emit_last  = (idx_ff + CW'(1)) == fill_ff;

   qse_ram #(.WIDTH(ValueWidth), .DEPTH(STORE_DEPTH)) u_value_ram (
      .clock (clock),
      .we    (vs_we),
      .waddr (vs_waddr),
      .wdata (vs_wdata),
      .re    (vs_re),
      .raddr (vs_raddr),
      .rdata (vs_rdata)
   );

   qse_ram #(.WIDTH(SW), .DEPTH(STORE_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (rs_we),
      .waddr (rs_waddr),
      .wdata (rs_wdata),
      .re    (rs_re),
      .raddr (rs_raddr),
      .rdata (rs_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_word.is_last) begin
               state_in = (load_cnt >= CW'(2)) ? ST_POP : ST_EMIT_RD;
            end
         end
         ST_POP:      state_in = (sp_ff == '0) ? ST_EMIT_RD : ST_POP_WAIT;
         ST_POP_WAIT: state_in = ST_PIV_WAIT;
         ST_PIV_WAIT: state_in = ST_CMP;
         ST_CMP: begin
            if (is_less) begin
               state_in = ST_SWP1;
            end else if (scan_more) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_FIN1;
            end
         end
         ST_SWP1:     state_in = ST_SWP2;
         ST_SWP2:     state_in = scan_more ? ST_CMP : ST_FIN1;
         ST_FIN1:     state_in = ST_FIN2;
         ST_FIN2:     state_in = ST_PUSH;
         ST_PUSH:     state_in = ST_POP;
         ST_EMIT_RD: begin
            if (out_free) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD:  state_in = emit_last ? ST_LOAD : ST_EMIT_RD;
         default:     state_in = ST_LOAD;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      vs_we = 1'b0;  vs_waddr = '0;  vs_wdata = '0;
      vs_re = 1'b0;  vs_raddr = '0;
      rs_we = 1'b0;  rs_waddr = '0;  rs_wdata = '0;
      rs_re = 1'b0;  rs_raddr = '0;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      scan_in    = scan_ff;
      place_in   = place_ff;
      pivot_in   = pivot_ff;
      hold_in    = hold_ff;
      sp_in      = sp_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      idx_in     = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (store_full) begin
                  dropped_in = 1'b1;
               end else begin
                  vs_we    = 1'b1;
                  vs_waddr = fill_ff[IW-1:0];
                  vs_wdata = req_word.value_in;
                  fill_in  = fill_ff + CW'(1);
               end
               if (req_word.is_last) begin
                  idx_in = '0;
                  sp_in  = '0;
                  // whole set as the first range
                  if (load_cnt >= CW'(2)) begin
                     rs_we    = 1'b1;
                     rs_waddr = '0;
                     rs_wdata = {IW'(0), IW'(load_cnt - CW'(1))};
                     sp_in    = IW'(1);
                  end
               end
            end
         end
         ST_POP: begin
            if (sp_ff != '0) begin
               sp_in    = sp_ff - IW'(1);
               rs_re    = 1'b1;
               rs_raddr = sp_ff - IW'(1);
            end
         end
         ST_POP_WAIT: begin
            lo_in    = rs_rdata[SW-1:IW];
            hi_in    = rs_rdata[IW-1:0];
            vs_re    = 1'b1;
            vs_raddr = rs_rdata[IW-1:0];
         end
         ST_PIV_WAIT: begin
            pivot_in = $signed(vs_rdata);
            place_in = lo_ff;
            scan_in  = lo_ff;
            vs_re    = 1'b1;
            vs_raddr = lo_ff;
         end
         ST_CMP: begin
            if (is_less) begin
               // keep the scanned word, fetch the one at the place mark
               hold_in  = $signed(vs_rdata);
               vs_re    = 1'b1;
               vs_raddr = place_ff;
            end else if (scan_more) begin
               scan_in  = scan_next[IW-1:0];
               vs_re    = 1'b1;
               vs_raddr = scan_next[IW-1:0];
            end else begin
               vs_re    = 1'b1;
               vs_raddr = place_ff;
            end
         end
         ST_SWP1: begin
            vs_we    = 1'b1;
            vs_waddr = scan_ff;
            vs_wdata = vs_rdata;
         end
         ST_SWP2: begin
            vs_we    = 1'b1;
            vs_waddr = place_ff;
            vs_wdata = hold_ff;
            place_in = place_next[IW-1:0];
            vs_re    = 1'b1;
            // read never hits the entry written this cycle
            if (scan_more) begin
               scan_in  = scan_next[IW-1:0];
               vs_raddr = scan_next[IW-1:0];
            end else begin
               vs_raddr = place_next[IW-1:0];
            end
         end
         ST_FIN1: begin
            vs_we    = 1'b1;
            vs_waddr = hi_ff;
            vs_wdata = vs_rdata;
         end
         ST_FIN2: begin
            vs_we    = 1'b1;
            vs_waddr = place_ff;
            vs_wdata = pivot_ff;
            // lower subrange, only if two wide or more
            if ({1'b0, place_ff} > ({1'b0, lo_ff} + (IW+1)'(1))) begin
               rs_we    = 1'b1;
               rs_waddr = sp_ff;
               rs_wdata = {lo_ff, place_ff - IW'(1)};
               sp_in    = sp_ff + IW'(1);
            end
         end
         ST_PUSH: begin
            if (place_next < {1'b0, hi_ff}) begin
               rs_we    = 1'b1;
               rs_waddr = sp_ff;
               rs_wdata = {place_next[IW-1:0], hi_ff};
               sp_in    = sp_ff + IW'(1);
            end
         end
         ST_EMIT_RD: begin
            if (out_free) begin
               vs_re    = 1'b1;
               vs_raddr = idx_ff[IW-1:0];
            end
         end
         ST_EMIT_LD: begin
            out_valid_in     = 1'b1;
            out_in.value_out = $signed(vs_rdata);
            out_in.last_out  = emit_last;
            out_in.overflow  = dropped_ff;
            idx_in           = idx_ff + CW'(1);
            if (emit_last) begin
               fill_in    = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         sp_ff        <= '0;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      scan_ff  <= scan_in;
      place_ff <= place_in;
      pivot_ff <= pivot_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   // fill count stays within the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   // range stack holds at most half the depth
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(sp_ff) <= STORE_DEPTH / 2))
      else $error("range stack deeper than possible");

   // place mark never runs ahead of the scan index while partitioning
   a_place_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP || state_ff == ST_SWP1 || state_ff == ST_SWP2)
         |-> (place_ff <= scan_ff && scan_ff < hi_ff))
      else $error("partition indexes out of order");

   // the final word of a set returns the block to loading with an empty store
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD && emit_last) |=> (state_ff == ST_LOAD && fill_ff == '0))
      else $error("set not cleared after emit");
endmodule
`default_nettype wire

// File: sim/tb.sv
// testbench for the quicksort engine: directed and random sets, self-checking order and flags
module tb;
   import qse_pkg::*;

   // store depth of the instance, matches the block default
   localparam int unsigned DEPTH = StoreDepthDefault;
   // random words after the directed table
   localparam int RANDOM_WORDS = 308;
   // once this many words went in, both sides stop idling
   localparam int CALM_AFTER = 290;
   // quiet cycles after the last expected word
   localparam int DRAIN_CYCLES = 40;
   // hard stop, far beyond the slowest legal run (quadratic sorts of full sets plus stalls)
   localparam int RUN_LIMIT = 5_000_000;

   localparam logic signed [31:0] MAX_VALUE = 32'h7fff_ffff;
   localparam logic signed [31:0] MIN_VALUE = 32'h8000_0000;

   // one row of the directed table; typed rows carry their own expected word
   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
      logic               typed;
      logic signed [31:0] exp_value;
      logic               exp_overflow;
   } sort_row_type;

   localparam int ROW_COUNT = 23;
   localparam sort_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      // single-word sets right after reset: result is the word itself
      '{32'sd0,     1'b1, 1'b1, 32'sd0,    1'b0},
      '{MAX_VALUE,  1'b1, 1'b1, MAX_VALUE, 1'b0},
      '{MIN_VALUE,  1'b1, 1'b1, MIN_VALUE, 1'b0},
      // both extremes in reverse order
      '{MAX_VALUE,  1'b0, 1'b0, 32'sd0,    1'b0},
      '{MIN_VALUE,  1'b1, 1'b0, 32'sd0,    1'b0},
      // all equal, pivot never beats anything
      '{32'sd5,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd5,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd5,     1'b1, 1'b0, 32'sd0,    1'b0},
      // descending across zero
      '{32'sd3,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd2,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd1,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd0,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{-32'sd1,    1'b1, 1'b0, 32'sd0,    1'b0},
      // already ascending, deepest partition chain
      '{-32'sd2,    1'b0, 1'b0, 32'sd0,    1'b0},
      '{-32'sd1,    1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd0,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd1,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd2,     1'b1, 1'b0, 32'sd0,    1'b0},
      // mixed extremes with a duplicate max
      '{MAX_VALUE,  1'b0, 1'b0, 32'sd0,    1'b0},
      '{-32'sd1,    1'b0, 1'b0, 32'sd0,    1'b0},
      '{MIN_VALUE,  1'b0, 1'b0, 32'sd0,    1'b0},
      '{32'sd0,     1'b0, 1'b0, 32'sd0,    1'b0},
      '{MAX_VALUE,  1'b1, 1'b0, 32'sd0,    1'b0}
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // model of the store: values kept in ascending order as they arrive
   logic signed [31:0] held_values[$];
   bit                 held_dropped = 1'b0;
   // sorted words still owed by the block, oldest first
   rsp_word_type       sorted_due[$];
   rsp_word_type       due_word;

   int error_count = 0;
   int words_sent = 0;
   bit calm = 1'b0;
   bit idling_on = 1'b1;
   int stall_left = 0;
   bit stall_now = 1'b0;

   quicksort_engine #(
      .STORE_DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("Verification failed");
      $finish;
   end

   // take one accepted word into the store model; on the final word of a set
   // the whole set comes out sorted, overflow on every word if anything was dropped
   task automatic absorb_word(input req_word_type w, input bit keep);
      int pos;
      rsp_word_type r;
      if (held_values.size() < DEPTH) begin
         pos = 0;
         // equal values: order among them carries no meaning
         while (pos < held_values.size() && held_values[pos] <= w.value_in) pos++;
         held_values.insert(pos, w.value_in);
      end else begin
         // store full, word is lost
         held_dropped = 1'b1;
      end
      if (w.is_last) begin
         for (int i = 0; i < held_values.size(); i++) begin
            r.value_out = held_values[i];
            r.last_out = (i == held_values.size() - 1);
            r.overflow = held_dropped;
            if (keep) sorted_due.push_back(r);
         end
         held_values.delete();
         held_dropped = 1'b0;
      end
   endtask

   // offer one word, with an optional idle burst in front of it
   task automatic send_word(input req_word_type w, input bit keep);
      if (!calm && idling_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      absorb_word(w, keep);
      words_sent++;
      if (words_sent >= CALM_AFTER) calm = 1'b1;
   endtask

   // extremes, a tight band around zero for duplicates, and full-range noise
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0: begin
            return MAX_VALUE;
         end
         1: begin
            return MIN_VALUE;
         end
         2, 3, 4: begin
            return $signed(32'($urandom_range(0, 8))) - 32'sd4;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // result side: bursts of random length, each a stall with one chance in four, else free flow
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (calm || !idling_on) begin
               stall_now = 1'b0;
               stall_left = 1;
            end else begin
               stall_now = ($urandom_range(0, 3) == 0);
               stall_left = $urandom_range(1, 18);
            end
         end
         rsp_stall <= stall_now;
         stall_left--;
      end
   end

   // every accepted result word against the oldest owed word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_due.size() == 0) begin
            error_count++;
            $display("%0t: word with nothing owed, expected none, actual value_out %0d",
                     $time, rsp_word.value_out);
         end else begin
            due_word = sorted_due.pop_front();
            if (rsp_word.value_out !== due_word.value_out) begin
               error_count++;
               $display("%0t: value_out expected %0d actual %0d",
                        $time, due_word.value_out, rsp_word.value_out);
            end
            if (rsp_word.last_out !== due_word.last_out) begin
               error_count++;
               $display("%0t: last_out expected %b actual %b",
                        $time, due_word.last_out, rsp_word.last_out);
            end
            if (rsp_word.overflow !== due_word.overflow) begin
               error_count++;
               $display("%0t: overflow expected %b actual %b",
                        $time, due_word.overflow, rsp_word.overflow);
            end
         end
      end
   end

   initial begin
      int set_idx;
      int set_size;
      req_word_type w;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; typed rows replace the model's word with the one in the table
      for (int k = 0; k < ROW_COUNT; k++) begin
         w.value_in = DIRECTED_ROWS[k].value;
         w.is_last = DIRECTED_ROWS[k].last;
         send_word(w, !DIRECTED_ROWS[k].typed);
         if (DIRECTED_ROWS[k].typed) begin
            sorted_due.push_back('{DIRECTED_ROWS[k].exp_value, 1'b1,
                                   DIRECTED_ROWS[k].exp_overflow});
         end
      end

      // random sets: mostly small, plus a full store, one that drops exactly
      // its final word, and one that drops several
      set_idx = 0;
      while (words_sent < ROW_COUNT + RANDOM_WORDS) begin
         case (set_idx)
            2: begin
               set_size = DEPTH;
            end
            5: begin
               set_size = DEPTH + 1;
            end
            9: begin
               set_size = DEPTH + $urandom_range(2, 6);
            end
            default: begin
               set_size = $urandom_range(1, 10);
            end
         endcase
         // every fourth set runs with no idling on either side
         idling_on = (set_idx % 4 != 3);
         for (int j = 0; j < set_size; j++) begin
            w.value_in = random_value();
            w.is_last = (j == set_size - 1);
            send_word(w, 1'b1);
         end
         set_idx++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/qse_pkg.sv
hdl/qse_ram.sv
hdl/quicksort_engine.sv
sim/tb.sv
